### design/pdc_pkg.sv
// Shared types and constants for the duplicate packet filter.
// Used by pdc_entry_eval and packet_dedup_cache_core; depends on nothing.
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int HASH_W = 48;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 6;
  localparam int CMD_W  = 2;

  localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd60000;

  localparam logic [CMD_W-1:0] CMD_LOOKUP        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT        = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_INSERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR         = 2'd3;

  // Verdict on one cache entry against the probe.
  typedef struct packed {
    logic live_hit;  // non-empty, unexpired and holding an equal hash
    logic free;      // empty or expired, so it may be overwritten
  } eval_t;

endpackage

### design/pdc_entry_ram.sv
// Single-port-write, single-port-read entry memory with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module pdc_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/pdc_entry_eval.sv
// Age and hash check of one entry read from the cache memory.
// Depends on pdc_pkg for the field widths and the eval_t result type.
`timescale 1ns / 1ps
module pdc_entry_eval #(
  parameter int KEY_W = 48
) (
  input  logic                      entry_valid,
  input  logic [pdc_pkg::TIME_W-1:0] entry_stamp,
  input  logic [KEY_W-1:0]          entry_key,
  input  logic [KEY_W-1:0]          probe_key,
  input  logic [pdc_pkg::TIME_W-1:0] now_ms,
  input  logic [pdc_pkg::TIME_W-1:0] expire_ms,
  output pdc_pkg::eval_t            verdict
);

  logic [pdc_pkg::TIME_W-1:0] stamp;
  logic [pdc_pkg::TIME_W-1:0] age;
  logic                       empty;
  logic                       expired;

  // An entry never written since reset or clear has a stamp of zero.
  assign stamp   = entry_valid ? entry_stamp : '0;
  assign empty   = (stamp == '0);
  assign age     = now_ms - stamp;
  assign expired = (age >= expire_ms);

  assign verdict.live_hit = !empty && !expired && (entry_key == probe_key);
  assign verdict.free     = empty || expired;

endmodule

### design/packet_dedup_cache_core.sv
// Top level of the duplicate packet filter: command sequencer, cursor, valid bits,
// configuration register and result register. Depends on pdc_pkg, pdc_entry_ram
// and pdc_entry_eval.
`timescale 1ns / 1ps
// A cache of recently seen packet hashes. Each transaction on the input channel
// carries a command, a hash and the current millisecond time, and produces exactly
// one result transaction (duplicate, inserted, slot). Lookups, inserts and
// lookup-then-insert commands are not overlapped: the entry memory has one read
// port, and every command reads each entry once in order starting at the cursor,
// then passes a write step that stores the chosen entry when the command inserts,
// and a done step that hands the result to the output register. A clear skips
// the memory pass and goes straight to the done step, because the per-entry valid
// bits are all dropped together. The result register decouples the two channels,
// so a new transaction is accepted while the previous result still waits for
// out_ready. The expiry setting is written through cfg_we/cfg_wdata and must only
// change while the block is idle.
module packet_dedup_cache_core #(
  parameter int ENTRIES    = 64,
  parameter int HASH_BYTES = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pdc_pkg::CMD_W-1:0]    in_command,
  input  logic [pdc_pkg::HASH_W-1:0]   in_hash,
  input  logic [pdc_pkg::TIME_W-1:0]   in_now_ms,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_duplicate,
  output logic                         out_inserted,
  output logic [pdc_pkg::SLOT_W-1:0]   out_slot,
  // Configuration port.
  input  logic                         cfg_we,
  input  logic [pdc_pkg::TIME_W-1:0]   cfg_wdata
);

  // Only the low HASH_BYTES bytes of the hash take part; the port holds at most six.
  localparam int KEY_W  = (8 * HASH_BYTES < pdc_pkg::HASH_W) ? 8 * HASH_BYTES
                                                             : pdc_pkg::HASH_W;
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int WORD_W = KEY_W + pdc_pkg::TIME_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] SCAN_LEN = CNT_W'(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and persistent control state.
  logic [pdc_pkg::TIME_W-1:0] expire_r;
  logic [IDX_W-1:0]           cursor_r;
  logic [ENTRIES-1:0]         valid_r;

  // The transaction being worked on.
  logic [pdc_pkg::CMD_W-1:0]  cmd_r;
  logic [KEY_W-1:0]           key_r;
  logic [pdc_pkg::TIME_W-1:0] now_r;

  // Scan bookkeeping: reads are issued at scan_addr_r, and each comes back in the
  // following cycle tagged with rd_idx_r.
  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           scan_addr_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic                       rd_vld_r;
  logic                       rd_entry_valid_r;
  logic                       hit_r;
  logic                       found_r;
  logic [IDX_W-1:0]           pick_r;

  // Result waiting to be moved into the output register.
  logic                       res_dup_r;
  logic                       res_ins_r;
  logic [pdc_pkg::SLOT_W-1:0] res_slot_r;

  logic                       out_valid_r;
  logic                       out_dup_r;
  logic                       out_ins_r;
  logic [pdc_pkg::SLOT_W-1:0] out_slot_r;

  logic                       in_fire;
  logic                       issue;
  logic                       scan_end;
  logic                       do_insert;
  logic                       want_lookup;
  logic                       out_free;
  logic                       ram_we;
  logic [WORD_W-1:0]          ram_wdata;
  logic [WORD_W-1:0]          ram_rdata;
  logic [IDX_W+pdc_pkg::SLOT_W-1:0] pick_ext;
  pdc_pkg::eval_t             verdict;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == S_SCAN) && (cnt_r < SCAN_LEN);
  assign scan_end  = (state_r == S_SCAN) && (cnt_r == SCAN_LEN);
  assign out_free  = !out_valid_r || out_ready;

  assign want_lookup = (cmd_r == pdc_pkg::CMD_LOOKUP) || (cmd_r == pdc_pkg::CMD_LOOKUP_INSERT);
  assign do_insert   = (cmd_r == pdc_pkg::CMD_INSERT) ||
                       ((cmd_r == pdc_pkg::CMD_LOOKUP_INSERT) && !hit_r);

  assign ram_we    = (state_r == S_WRITE) && do_insert;
  assign ram_wdata = {key_r, now_r};
  // The slot field reports the low six bits of the entry index.
  assign pick_ext  = {{pdc_pkg::SLOT_W{1'b0}}, pick_r};

  pdc_entry_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_r),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  pdc_entry_eval #(
    .KEY_W (KEY_W)
  ) u_eval (
    .entry_valid (rd_entry_valid_r),
    .entry_stamp (ram_rdata[pdc_pkg::TIME_W-1:0]),
    .entry_key   (ram_rdata[WORD_W-1:pdc_pkg::TIME_W]),
    .probe_key   (key_r),
    .now_ms      (now_r),
    .expire_ms   (expire_r),
    .verdict     (verdict)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_command == pdc_pkg::CMD_CLEAR) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      expire_r    <= pdc_pkg::EXPIRE_RESET;
      cursor_r    <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        expire_r <= cfg_wdata;
      end
      if (in_fire && (in_command == pdc_pkg::CMD_CLEAR)) begin
        // Dropping every valid bit empties the whole store at once.
        valid_r  <= '0;
        cursor_r <= '0;
      end else if (ram_we) begin
        valid_r[pick_r] <= 1'b1;
      end
      // The cursor advances on every insert, wherever the entry landed.
      if ((state_r == S_WRITE) && do_insert) begin
        cursor_r <= (cursor_r == LAST_IDX) ? '0 : cursor_r + 1'b1;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r       <= in_command;
      key_r       <= in_hash[KEY_W-1:0];
      now_r       <= in_now_ms;
      cnt_r       <= '0;
      scan_addr_r <= cursor_r;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      pick_r      <= cursor_r;
      res_dup_r   <= 1'b0;
      res_ins_r   <= 1'b0;
      res_slot_r  <= '0;
    end

    rd_vld_r <= issue;
    if (issue) begin
      cnt_r            <= cnt_r + 1'b1;
      scan_addr_r      <= (scan_addr_r == LAST_IDX) ? '0 : scan_addr_r + 1'b1;
      rd_idx_r         <= scan_addr_r;
      rd_entry_valid_r <= valid_r[scan_addr_r];
    end

    // Entries come back in cursor order, so the first free one seen is the pick.
    if (rd_vld_r && (state_r == S_SCAN)) begin
      if (verdict.live_hit) begin
        hit_r <= 1'b1;
      end
      if (!found_r && verdict.free) begin
        found_r <= 1'b1;
        pick_r  <= rd_idx_r;
      end
    end

    if (state_r == S_WRITE) begin
      res_dup_r  <= want_lookup && hit_r;
      res_ins_r  <= do_insert;
      res_slot_r <= do_insert ? pick_ext[pdc_pkg::SLOT_W-1:0] : '0;
    end

    if ((state_r == S_DONE) && out_free) begin
      out_dup_r  <= res_dup_r;
      out_ins_r  <= res_ins_r;
      out_slot_r <= res_slot_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_duplicate = out_dup_r;
  assign out_inserted  = out_ins_r;
  assign out_slot      = out_slot_r;

  // The cursor never leaves the entry range, also for a depth that is not a power of two.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= LAST_IDX)
    else $error("cursor outside the entry range");

  // An inserted entry is live in the valid bits from the next cycle on.
  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(pick_r)])
    else $error("written entry not marked valid");

  // A clear empties the store and rewinds the cursor.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_command == pdc_pkg::CMD_CLEAR)) |=> (valid_r == '0) && (cursor_r == '0))
    else $error("clear left state behind");

  // A result never reports both a duplicate and an insert.
  a_dup_xor_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_dup_r && out_ins_r))
    else $error("duplicate and inserted both set");

  // A result without an insert reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ins_r) |-> (out_slot_r == '0))
    else $error("slot reported without an insert");

endmodule
